@@ rtl/core/encoder_to_opening_interpolator_top_defines.svh @@
// Assertion macros for the encoder-to-opening interpolator.
`ifndef ENCODER_TO_OPENING_INTERPOLATOR_TOP_DEFINES_SVH
`define ENCODER_TO_OPENING_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EOI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interpolator check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define EOI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interpolator check failed");

`endif

@@ rtl/core/eoi_pkg.sv @@
// Package with the types and constants of the encoder-to-opening interpolator.
package eoi_pkg;

	localparam int MAX_POINTS = 16;
	localparam int MIN_POINTS = 4;

	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_CONVERT = 1'b1;

	localparam logic MODE_LINE  = 1'b0;
	localparam logic MODE_TABLE = 1'b1;

	localparam logic [2:0] CFG_CALC_MODE   = 3'd0;
	localparam logic [2:0] CFG_COUNT_DIR   = 3'd1;
	localparam logic [2:0] CFG_POINT_COUNT = 3'd2;
	localparam logic [2:0] CFG_MIN_ENCODER = 3'd3;
	localparam logic [2:0] CFG_MAX_ENCODER = 3'd4;
	localparam logic [2:0] CFG_MIN_OPENING = 3'd5;
	localparam logic [2:0] CFG_MAX_OPENING = 3'd6;

	typedef struct packed {
		logic               req_type;
		logic [3:0]         point_index;
		logic [31:0]        point_encoder;
		logic signed [31:0] point_opening;
		logic [31:0]        encoder_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] opening;
		logic               status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MUL,
		ST_DIV,
		ST_SAT,
		ST_DONE
	} state_t;

endpackage

@@ rtl/core/encoder_to_opening_interpolator_top.sv @@
// Top level of the encoder-to-opening interpolator.
//
// Each input transfer is either a calibration point write or a conversion of an
// absolute encoder reading into a gate opening (signed Q16.16); each input
// transfer yields exactly one output transfer with the opening and a status bit.
// Both channels use valid and stall; a transfer happens when valid is high and
// stall is low. The configuration port is a plain write port; the user must
// write it only while the block is idle, which the block itself does not enforce.
// The calibration table lives in one synchronous memory with one read port.
// A line-mode conversion runs operand setup, one 32x32 multiply, a restoring
// divider that yields one quotient bit per cycle, saturation and output load.
// A table-mode conversion first scans the table, one memory read per cycle,
// and then runs the same steps. A point write goes straight to output load.
// Invalid setups and readings past the last point skip the arithmetic.
// One item is in work at a time; the input is stalled until its result has
// been placed in the output register, so the next item may be accepted while
// that result still waits for the receiver. When the receiver stalls, the
// output register holds its transfer and a finished item waits in its last step.
// Reset clears the configuration registers and control state; the table
// contents stay undefined until written.
module encoder_to_opening_interpolator_top #(
	parameter int MAX_POINTS = eoi_pkg::MAX_POINTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  eoi_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output eoi_pkg::out_item_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = AW + 1;

	// Configuration registers.
	logic        calc_mode_q;
	logic        count_dir_q;
	logic [4:0]  point_count_q;
	logic [31:0] min_enc_q;
	logic [31:0] max_enc_q;
	logic [31:0] min_op_q;
	logic [31:0] max_op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_mode_q   <= 1'b0;
			count_dir_q   <= 1'b0;
			point_count_q <= '0;
			min_enc_q     <= '0;
			max_enc_q     <= '0;
			min_op_q      <= '0;
			max_op_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				eoi_pkg::CFG_CALC_MODE:   calc_mode_q   <= cfg_data[0];
				eoi_pkg::CFG_COUNT_DIR:   count_dir_q   <= cfg_data[0];
				eoi_pkg::CFG_POINT_COUNT: point_count_q <= cfg_data[4:0];
				eoi_pkg::CFG_MIN_ENCODER: min_enc_q     <= cfg_data;
				eoi_pkg::CFG_MAX_ENCODER: max_enc_q     <= cfg_data;
				eoi_pkg::CFG_MIN_OPENING: min_op_q      <= cfg_data;
				eoi_pkg::CFG_MAX_OPENING: max_op_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	eoi_pkg::state_t state_q, state_d;

	logic in_acc;
	assign in_stall = (state_q != eoi_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// Calibration memory: {encoder, opening} per entry.
	logic [63:0]   mem_q [MAX_POINTS];
	logic          mem_we;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] rd_cnt_q;
	logic [63:0]   rd_data_s1;
	logic          rd_vld_s1;
	logic [CW-1:0] rd_k_s1;
	logic [CW-1:0] last_k;
	logic          issue;

	assign wr_addr = AW'(in_data.point_index);
	assign mem_we  = in_acc && (in_data.req_type == eoi_pkg::REQ_WRITE)
		&& (int'(in_data.point_index) < MAX_POINTS);
	assign last_k  = CW'(point_count_q - 5'd1);
	assign issue   = (state_q == eoi_pkg::ST_SCAN) && (rd_cnt_q <= last_k);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= {in_data.point_encoder, in_data.point_opening};
		end
		rd_data_s1 <= mem_q[rd_cnt_q[AW-1:0]];
		rd_k_s1    <= rd_cnt_q;
	end

	// Item and scan results.
	logic        count_ok;
	logic [31:0] enc_q;
	logic [31:0] prev_enc_q, prev_op_q;
	logic [31:0] s0_lo_e_q, s0_lo_o_q, s0_hi_e_q, s0_hi_o_q;
	logic [31:0] sg_lo_e_q, sg_lo_o_q, sg_hi_e_q, sg_hi_o_q;
	logic [31:0] last_e_q, last_o_q;
	logic        found_q, zs_err_q;
	logic [31:0] cur_e, cur_o;
	logic        in_seg;

	assign count_ok = (point_count_q >= 5'(eoi_pkg::MIN_POINTS))
		&& (int'(point_count_q) <= MAX_POINTS);
	assign cur_e  = rd_data_s1[63:32];
	assign cur_o  = rd_data_s1[31:0];
	assign in_seg = count_dir_q ? (enc_q <= prev_enc_q && enc_q > cur_e)
		: (enc_q >= prev_enc_q && enc_q < cur_e);

	// Operand selection for the interpolation.
	logic        dec_err, dec_direct, anc_hi;
	logic [31:0] dec_res, lo_e, lo_o, hi_e, hi_o, anc_e;
	logic [32:0] d_op, span, enc_dist;
	logic        below, past;

	always_comb begin
		dec_err    = 1'b0;
		dec_direct = 1'b0;
		dec_res    = '0;
		anc_hi     = 1'b0;
		lo_e = min_enc_q;
		lo_o = min_op_q;
		hi_e = max_enc_q;
		hi_o = max_op_q;
		below = count_dir_q ? (enc_q > s0_lo_e_q) : (enc_q < s0_lo_e_q);
		past  = count_dir_q ? (enc_q <= last_e_q) : (enc_q >= last_e_q);
		if (calc_mode_q == eoi_pkg::MODE_LINE) begin
			dec_err = (min_enc_q == max_enc_q);
		end else if (zs_err_q) begin
			dec_err = 1'b1;
		end else if (below) begin
			lo_e = s0_lo_e_q;
			lo_o = s0_lo_o_q;
			hi_e = s0_hi_e_q;
			hi_o = s0_hi_o_q;
		end else if (past) begin
			dec_direct = 1'b1;
			dec_res    = last_o_q;
		end else if (found_q) begin
			lo_e   = sg_lo_e_q;
			lo_o   = sg_lo_o_q;
			hi_e   = sg_hi_e_q;
			hi_o   = sg_hi_o_q;
			anc_hi = count_dir_q;
		end else begin
			dec_err = 1'b1;
		end
		anc_e    = anc_hi ? hi_e : lo_e;
		d_op     = {hi_o[31], hi_o} - {lo_o[31], lo_o};
		span     = {1'b0, hi_e} - {1'b0, lo_e};
		enc_dist = {1'b0, enc_q} - {1'b0, anc_e};
	end

	// Arithmetic registers.
	logic        neg_q;
	logic [31:0] anc_q, mdop_q, mdist_q, mspan_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [5:0]  div_cnt_q;
	logic [31:0] res_q;
	logic        err_q;
	logic [32:0] rem_sh;
	logic [33:0] diff;
	logic        ge;
	logic [34:0] sum;
	logic [31:0] sat_res;

	assign rem_sh = {rem_q[31:0], quo_q[63]};
	assign diff   = {1'b0, rem_sh} - {2'b0, mspan_q};
	assign ge     = !diff[33];

	always_comb begin
		sum = neg_q ? ({{3{anc_q[31]}}, anc_q} - {1'b0, quo_q[33:0]})
			: ({{3{anc_q[31]}}, anc_q} + {1'b0, quo_q[33:0]});
		if (|quo_q[63:33]) begin
			sat_res = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if ($signed(sum) > $signed(35'sh0_7FFF_FFFF)) begin
			sat_res = 32'h7FFF_FFFF;
		end else if ($signed(sum) < -$signed(35'sh0_8000_0000)) begin
			sat_res = 32'h8000_0000;
		end else begin
			sat_res = sum[31:0];
		end
	end

	// Output register.
	logic      out_valid_q;
	logic      out_free;
	eoi_pkg::out_item_t out_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eoi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			eoi_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (in_data.req_type == eoi_pkg::REQ_WRITE) begin
						state_d = eoi_pkg::ST_DONE;
					end else if (calc_mode_q == eoi_pkg::MODE_LINE) begin
						state_d = eoi_pkg::ST_DECIDE;
					end else if (!count_ok) begin
						state_d = eoi_pkg::ST_DONE;
					end else begin
						state_d = eoi_pkg::ST_SCAN;
					end
				end
			end
			eoi_pkg::ST_SCAN: begin
				if (!issue && !rd_vld_s1) state_d = eoi_pkg::ST_DECIDE;
			end
			eoi_pkg::ST_DECIDE: begin
				state_d = (dec_err || dec_direct) ? eoi_pkg::ST_DONE : eoi_pkg::ST_MUL;
			end
			eoi_pkg::ST_MUL: state_d = eoi_pkg::ST_DIV;
			eoi_pkg::ST_DIV: begin
				if (div_cnt_q == 6'd63) state_d = eoi_pkg::ST_SAT;
			end
			eoi_pkg::ST_SAT: state_d = eoi_pkg::ST_DONE;
			eoi_pkg::ST_DONE: begin
				if (out_free) state_d = eoi_pkg::ST_IDLE;
			end
			default: state_d = eoi_pkg::ST_IDLE;
		endcase
	end

	// Control registers that need reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (state_q == eoi_pkg::ST_IDLE) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (state_q == eoi_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			eoi_pkg::ST_IDLE: begin
				enc_q    <= in_data.encoder_value;
				found_q  <= 1'b0;
				zs_err_q <= 1'b0;
				res_q    <= '0;
				err_q    <= (in_data.req_type == eoi_pkg::REQ_CONVERT)
					&& (calc_mode_q == eoi_pkg::MODE_TABLE) && !count_ok;
			end
			eoi_pkg::ST_SCAN: begin
				if (rd_vld_s1) begin
					prev_enc_q <= cur_e;
					prev_op_q  <= cur_o;
					if (rd_k_s1 == '0) begin
						s0_lo_e_q <= cur_e;
						s0_lo_o_q <= cur_o;
					end else begin
						if (cur_e == prev_enc_q) zs_err_q <= 1'b1;
						if (!found_q && in_seg) begin
							found_q   <= 1'b1;
							sg_lo_e_q <= prev_enc_q;
							sg_lo_o_q <= prev_op_q;
							sg_hi_e_q <= cur_e;
							sg_hi_o_q <= cur_o;
						end
					end
					if (rd_k_s1 == CW'(1)) begin
						s0_hi_e_q <= cur_e;
						s0_hi_o_q <= cur_o;
					end
					if (rd_k_s1 == last_k) begin
						last_e_q <= cur_e;
						last_o_q <= cur_o;
					end
				end
			end
			eoi_pkg::ST_DECIDE: begin
				err_q   <= dec_err;
				res_q   <= dec_res;
				neg_q   <= d_op[32] ^ enc_dist[32] ^ span[32];
				anc_q   <= anc_hi ? hi_o : lo_o;
				mdop_q  <= d_op[32] ? (~d_op[31:0] + 32'd1) : d_op[31:0];
				mdist_q <= enc_dist[32] ? (~enc_dist[31:0] + 32'd1) : enc_dist[31:0];
				mspan_q <= span[32] ? (~span[31:0] + 32'd1) : span[31:0];
			end
			eoi_pkg::ST_MUL: begin
				quo_q     <= {32'd0, mdop_q} * {32'd0, mdist_q};
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			eoi_pkg::ST_DIV: begin
				rem_q     <= ge ? diff[32:0] : rem_sh;
				quo_q     <= {quo_q[62:0], ge};
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			eoi_pkg::ST_SAT: begin
				res_q <= sat_res;
			end
			eoi_pkg::ST_DONE: begin
				if (out_free) begin
					out_q.opening <= err_q ? 32'sd0 : $signed(res_q);
					out_q.status  <= err_q;
				end
			end
			default: ;
		endcase
	end

	`include "encoder_to_opening_interpolator_top_defines.svh"

	`EOI_ASSERT_NOW(a_accept_idle, in_valid && !in_stall, state_q == eoi_pkg::ST_IDLE)
	`EOI_ASSERT_NEXT(a_done_loads, state_q == eoi_pkg::ST_DONE && out_free, out_valid)
	`EOI_ASSERT_NOW(a_err_zero, out_valid && out_data.status, out_data.opening == 32'sd0)

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the encoder-to-opening interpolator with its own opening predictor.
module testbench;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 150;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int QUIET_AFTER    = 1150;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	eoi_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	eoi_pkg::out_item_t out_data;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// Predictor copy of the calibration table and the configuration registers.
	logic [31:0] tbl_enc [eoi_pkg::MAX_POINTS];
	logic [31:0] tbl_op  [eoi_pkg::MAX_POINTS];
	logic        m_mode = eoi_pkg::MODE_LINE;
	logic        m_dir = 1'b0;
	logic [4:0]  m_count = '0;
	logic [31:0] m_min_enc = '0;
	logic [31:0] m_max_enc = '0;
	logic [31:0] m_min_op = '0;
	logic [31:0] m_max_op = '0;

	eoi_pkg::out_item_t expected_openings[$];
	int        mismatches = 0;
	int        items_sent = 0;
	int        idle_cycles = 0;
	bit        quiet = 1'b0;
	int        stall_burst = 0;

	encoder_to_opening_interpolator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint as_signed(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint as_unsigned(logic [31:0] v);
		return longint'({32'd0, v});
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// anchor + trunc(d_op * enc_dist / span), saturated to the signed 32-bit range.
	function automatic logic [31:0] interp_q16(longint anchor, longint d_op, longint enc_dist,
			longint span);
		bit          neg;
		logic [63:0] q;
		longint      r;
		neg = ((d_op < 0) != (enc_dist < 0)) != (span < 0);
		q = (magnitude(d_op) * magnitude(enc_dist)) / magnitude(span);
		if (q > 64'h1_FFFF_FFFF)
			r = neg ? -64'sd2147483648 : 64'sd2147483647;
		else
			r = anchor + (neg ? -longint'(q) : longint'(q));
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic logic [31:0] segment_opening(int i, int a, logic [31:0] e);
		return interp_q16(as_signed(tbl_op[a]),
			as_signed(tbl_op[i + 1]) - as_signed(tbl_op[i]),
			as_unsigned(e) - as_unsigned(tbl_enc[a]),
			as_unsigned(tbl_enc[i + 1]) - as_unsigned(tbl_enc[i]));
	endfunction

	// Applies one accepted item to the predictor and returns the result it should produce.
	function automatic eoi_pkg::out_item_t predict_opening(eoi_pkg::in_item_t it);
		eoi_pkg::out_item_t res;
		logic [31:0] e;
		int          last;
		bit          ok;
		bit          found;
		res = '0;
		e = it.encoder_value;
		ok = 1'b1;
		if (it.req_type == eoi_pkg::REQ_WRITE) begin
			tbl_enc[it.point_index] = it.point_encoder;
			tbl_op[it.point_index] = it.point_opening;
			return res;
		end
		if (m_mode == eoi_pkg::MODE_LINE) begin
			if (m_max_enc == m_min_enc) begin
				ok = 1'b0;
			end else begin
				res.opening = interp_q16(as_signed(m_min_op),
					as_signed(m_max_op) - as_signed(m_min_op),
					as_unsigned(e) - as_unsigned(m_min_enc),
					as_unsigned(m_max_enc) - as_unsigned(m_min_enc));
			end
		end else if (m_count < eoi_pkg::MIN_POINTS || m_count > eoi_pkg::MAX_POINTS) begin
			ok = 1'b0;
		end else begin
			last = m_count - 1;
			for (int i = 0; i < last; i++)
				if (tbl_enc[i + 1] == tbl_enc[i])
					ok = 1'b0;
			if (ok) begin
				found = 1'b1;
				if (m_dir == 1'b0) begin
					if (e < tbl_enc[0]) begin
						res.opening = segment_opening(0, 0, e);
					end else if (e >= tbl_enc[last]) begin
						res.opening = tbl_op[last];
					end else begin
						found = 1'b0;
						for (int i = 0; i < last; i++)
							if (!found && e >= tbl_enc[i] && e < tbl_enc[i + 1]) begin
								res.opening = segment_opening(i, i, e);
								found = 1'b1;
							end
					end
				end else begin
					if (e > tbl_enc[0]) begin
						res.opening = segment_opening(0, 0, e);
					end else if (e <= tbl_enc[last]) begin
						res.opening = tbl_op[last];
					end else begin
						found = 1'b0;
						for (int i = 0; i < last; i++)
							if (!found && e <= tbl_enc[i] && e > tbl_enc[i + 1]) begin
								res.opening = segment_opening(i, i + 1, e);
								found = 1'b1;
							end
					end
				end
				ok = found;
			end
		end
		if (!ok) begin
			res.opening = '0;
			res.status = 1'b1;
		end
		return res;
	endfunction

	// Output checker: every output transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_openings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: opening %h status %b",
						out_data.opening, out_data.status);
			end else begin
				if (out_data.opening !== expected_openings[0].opening ||
						out_data.status !== expected_openings[0].status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected opening %h status %b, got opening %h status %b",
							expected_openings[0].opening, expected_openings[0].status,
							out_data.opening, out_data.status);
				end
				void'(expected_openings.pop_front());
			end
		end
	end

	// Receiver back-pressure in random bursts; switched off for the last part of the run.
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			stall_burst = 0;
			out_stall <= 1'b0;
		end else if (stall_burst > 0) begin
			stall_burst--;
			out_stall <= 1'b1;
		end else if ($urandom_range(4) == 0) begin
			stall_burst = $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: too many cycles in a row without any transfer ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_openings.size());
			$display("status: fail");
			$finish;
		end
	end

	// Sends one item, now and then with a random gap in front of it, and records its expected result.
	task automatic send_item(eoi_pkg::in_item_t it);
		int gap;
		if (!quiet && $urandom_range(3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		expected_openings.push_back(predict_opening(it));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_point(logic [3:0] idx, logic [31:0] enc, logic [31:0] op);
		eoi_pkg::in_item_t it;
		it.req_type = eoi_pkg::REQ_WRITE;
		it.point_index = idx;
		it.point_encoder = enc;
		it.point_opening = op;
		it.encoder_value = $urandom;
		send_item(it);
	endtask

	task automatic convert(logic [31:0] e);
		eoi_pkg::in_item_t it;
		it.req_type = eoi_pkg::REQ_CONVERT;
		it.point_index = 4'($urandom_range(15));
		it.point_encoder = $urandom;
		it.point_opening = $urandom;
		it.encoder_value = e;
		send_item(it);
	endtask

	// Lets every outstanding result come back before the registers are touched.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_openings.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			eoi_pkg::CFG_CALC_MODE:   m_mode = val[0];
			eoi_pkg::CFG_COUNT_DIR:   m_dir = val[0];
			eoi_pkg::CFG_POINT_COUNT: m_count = val[4:0];
			eoi_pkg::CFG_MIN_ENCODER: m_min_enc = val;
			eoi_pkg::CFG_MAX_ENCODER: m_max_enc = val;
			eoi_pkg::CFG_MIN_OPENING: m_min_op = val;
			eoi_pkg::CFG_MAX_OPENING: m_max_op = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic cfg_close();
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Line mode: zero span after reset, full range, saturation and a falling line.
	task automatic test_line_mode();
		convert(32'd12345);
		wait_idle();
		set_reg(eoi_pkg::CFG_MIN_ENCODER, 32'd0);
		set_reg(eoi_pkg::CFG_MAX_ENCODER, 32'hFFFF_FFFF);
		set_reg(eoi_pkg::CFG_MIN_OPENING, 32'h8000_0000);
		set_reg(eoi_pkg::CFG_MAX_OPENING, 32'h7FFF_FFFF);
		cfg_close();
		convert(32'd0);
		convert(32'hFFFF_FFFF);
		convert(32'h7FFF_FFFF);
		wait_idle();
		// A one-count span makes readings far from it overflow in both directions.
		set_reg(eoi_pkg::CFG_MIN_ENCODER, 32'd1000);
		set_reg(eoi_pkg::CFG_MAX_ENCODER, 32'd1001);
		cfg_close();
		convert(32'hFFFF_FFFF);
		convert(32'd0);
		wait_idle();
		set_reg(eoi_pkg::CFG_MIN_ENCODER, 32'd2000);
		set_reg(eoi_pkg::CFG_MAX_ENCODER, 32'd1000);
		set_reg(eoi_pkg::CFG_MIN_OPENING, 32'h0001_0000);
		set_reg(eoi_pkg::CFG_MAX_OPENING, 32'hFFFE_0000);
		cfg_close();
		convert(32'd1500);
		convert(32'd3000);
	endtask

	// Loads every table slot so that no later lookup can read an unwritten entry.
	task automatic test_point_load();
		write_point(4'd0, 32'd100, 32'd0);
		write_point(4'd1, 32'd200, 32'h0001_0000);
		write_point(4'd2, 32'd300, 32'hFFFE_0000);
		write_point(4'd3, 32'd400, 32'h7FFF_FFFF);
		for (int i = 4; i < eoi_pkg::MAX_POINTS; i++)
			write_point(4'(i),
				(i == eoi_pkg::MAX_POINTS - 1) ? 32'hFFFF_FFFF : 32'(i * 100 + 100),
				(i == eoi_pkg::MAX_POINTS - 1) ? 32'h8000_0000 : 32'(i * 65536));
	endtask

	// Table mode: both directions, both ends, bad counts and a zero span.
	task automatic test_table_mode();
		wait_idle();
		set_reg(eoi_pkg::CFG_CALC_MODE, 32'(eoi_pkg::MODE_TABLE));
		set_reg(eoi_pkg::CFG_COUNT_DIR, 32'd0);
		set_reg(eoi_pkg::CFG_POINT_COUNT, 32'd4);
		cfg_close();
		convert(32'd0);
		convert(32'd150);
		convert(32'd400);
		convert(32'hFFFF_FFFF);
		wait_idle();
		set_reg(eoi_pkg::CFG_POINT_COUNT, 32'd16);
		cfg_close();
		convert(32'd1234);
		wait_idle();
		set_reg(eoi_pkg::CFG_POINT_COUNT, 32'd3);
		cfg_close();
		convert(32'd150);
		wait_idle();
		set_reg(eoi_pkg::CFG_POINT_COUNT, 32'd17);
		cfg_close();
		convert(32'd150);
		wait_idle();
		set_reg(eoi_pkg::CFG_POINT_COUNT, 32'd4);
		cfg_close();
		// Two neighbors with the same reading make the setup invalid.
		write_point(4'd2, 32'd200, 32'hFFFE_0000);
		convert(32'd150);
		wait_idle();
		set_reg(eoi_pkg::CFG_COUNT_DIR, 32'd1);
		cfg_close();
		write_point(4'd0, 32'd400, 32'd0);
		write_point(4'd1, 32'd300, 32'h0001_0000);
		write_point(4'd2, 32'd200, 32'hFFFE_0000);
		write_point(4'd3, 32'd100, 32'h7FFF_FFFF);
		convert(32'd500);
		convert(32'd250);
		convert(32'd100);
		convert(32'd0);
	endtask

	function automatic logic [31:0] random_opening();
		if ($urandom_range(1) == 0)
			return $urandom;
		return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
	endfunction

	function automatic logic [31:0] line_reading();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
			default: return $urandom_range(m_min_enc, m_max_enc);
		endcase
	endfunction

	function automatic logic [31:0] table_reading();
		int n;
		int i;
		n = (m_count > eoi_pkg::MAX_POINTS) ? eoi_pkg::MAX_POINTS : m_count;
		if (n < 2)
			return $urandom;
		i = $urandom_range(0, n - 2);
		case ($urandom_range(9))
			0: return tbl_enc[$urandom_range(0, n - 1)];
			1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
			2, 3: return $urandom;
			default: return $urandom_range(tbl_enc[i], tbl_enc[i + 1]);
		endcase
	endfunction

	// Writes a table that rises or falls along its slots, now and then with a repeated reading.
	task automatic load_monotone_table(int n);
		logic [63:0] enc;
		logic [63:0] step_max;
		enc = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom);
		step_max = (64'hFFFF_FFFF - enc) / n;
		if (step_max == 0) begin
			enc = 64'd0;
			step_max = 64'hFFFF_FFFF / n;
		end
		if ($urandom_range(1) == 0 && step_max > 1000)
			step_max = 1000;
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(39) != 0)
				enc = enc + $urandom_range(1, 32'(step_max));
			write_point(4'(i), m_dir ? ~enc[31:0] : enc[31:0], random_opening());
		end
	endtask

	// Random phases: a fresh setting, a monotone table where it applies, then readings.
	task automatic test_random_phases();
		int start;
		int n;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent - start > QUIET_AFTER)
				quiet = 1'b1;
			wait_idle();
			set_reg(eoi_pkg::CFG_COUNT_DIR, $urandom_range(1));
			if ($urandom_range(9) < 3) begin
				set_reg(eoi_pkg::CFG_CALC_MODE, 32'(eoi_pkg::MODE_LINE));
				set_reg(eoi_pkg::CFG_MIN_ENCODER, $urandom_range(4) ? $urandom : 32'd0);
				set_reg(eoi_pkg::CFG_MAX_ENCODER, ($urandom_range(29) == 0) ? m_min_enc :
					($urandom_range(4) ? $urandom : 32'hFFFF_FFFF));
				set_reg(eoi_pkg::CFG_MIN_OPENING, random_opening());
				set_reg(eoi_pkg::CFG_MAX_OPENING, random_opening());
				cfg_close();
				repeat ($urandom_range(20, 40)) convert(line_reading());
			end else begin
				n = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(4, 16);
				set_reg(eoi_pkg::CFG_CALC_MODE, 32'(eoi_pkg::MODE_TABLE));
				set_reg(eoi_pkg::CFG_POINT_COUNT, 32'(n));
				cfg_close();
				load_monotone_table((n > eoi_pkg::MAX_POINTS) ? eoi_pkg::MAX_POINTS :
					((n < 2) ? 2 : n));
				repeat ($urandom_range(20, 40)) begin
					if ($urandom_range(14) == 0)
						write_point(4'($urandom_range(15)), $urandom, $urandom);
					else
						convert(table_reading());
				end
			end
		end
	endtask

	initial begin
		for (int i = 0; i < eoi_pkg::MAX_POINTS; i++) begin
			tbl_enc[i] = '0;
			tbl_op[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_line_mode();
		test_point_load();
		test_table_mode();
		test_random_phases();
		in_valid <= 1'b0;
		while (expected_openings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_openings.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule
